// ===== rtl/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg - shared types for the indexed list core
// Operation and status codes, plus the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package ilir_pkg;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_POP    = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // read address source
  typedef enum logic [1:0] {
    RD_POS  = 2'd0,
    RD_LAST = 2'd1,
    RD_PTR  = 2'd2
  } rd_sel_t;

  // write address source
  typedef enum logic [1:0] {
    WR_COUNT  = 2'd0,
    WR_POS    = 2'd1,
    WR_PTR_UP = 2'd2,
    WR_PTR_DN = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic    load_in;      // capture the accepted item
    logic    sts_latch;    // hold the check result of this item
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    wr_src_rdata; // write the word just read instead of the item word
    logic    ptr_load;
    logic    ptr_sel_pos;  // 1: load position + 1, 0: load count - 1
    logic    ptr_inc;
    logic    ptr_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    val_capture;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_t     op;
    status_t chk;
    logic    pos_at_count;
    logic    pos_at_last;
    logic    ptr_at_pos;
    logic    ptr_at_last;
    logic    out_free;
  } dp_sts_t;

endpackage

// ===== rtl/ilir_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ilir_cmd_if - operation channel
// Valid/ready channel that carries one list operation per item.
// ----------------------------------------------------------------------------
interface ilir_cmd_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  op;
  logic        [2:0]  position;
  logic signed [31:0] item;

  modport source (output valid, output op, output position, output item, input ready);
  modport sink (input valid, input op, input position, input item, output ready);
endinterface

// ===== rtl/ilir_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ilir_rsp_if - result channel
// Valid/ready channel that carries one result item per operation.
// ----------------------------------------------------------------------------
interface ilir_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [1:0]  status;
  logic        [3:0]  count;

  modport source (output valid, output value, output status, output count, input ready);
  modport sink (input valid, input value, input status, input count, output ready);
endinterface

// ===== rtl/ilir_ram.sv =====
// ----------------------------------------------------------------------------
// ilir_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ilir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ilir_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilir_ctrl - list operation sequencer
// Decides each operation and steps the datapath through reads, entry moves
// and the final write, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ilir_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ilir_pkg::dp_sts_t sts,
  output ilir_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RD_WAIT,
    S_RM_WAIT,
    S_MOVE_RD,
    S_MOVE_WR,
    S_INS_WR,
    S_FINISH
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.sts_latch = 1'b1;
        state_next    = S_FINISH;
        if (sts.chk == ilir_pkg::ST_OK) begin
          case (sts.op)
            ilir_pkg::OP_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ilir_pkg::RD_POS;
              state_next = S_RD_WAIT;
            end
            ilir_pkg::OP_APPEND: begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = ilir_pkg::WR_COUNT;
              cmd.cnt_inc = 1'b1;
            end
            ilir_pkg::OP_INSERT: begin
              if (sts.pos_at_count) begin
                state_next = S_INS_WR;
              end else begin
                cmd.ptr_load    = 1'b1;
                cmd.ptr_sel_pos = 1'b0;
                state_next      = S_MOVE_RD;
              end
            end
            ilir_pkg::OP_POP: begin
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = ilir_pkg::RD_LAST;
              cmd.cnt_dec = 1'b1;
              state_next  = S_RD_WAIT;
            end
            ilir_pkg::OP_REMOVE: begin
              cmd.rd_en       = 1'b1;
              cmd.rd_sel      = ilir_pkg::RD_POS;
              cmd.ptr_load    = 1'b1;
              cmd.ptr_sel_pos = 1'b1;
              state_next      = S_RM_WAIT;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.val_capture = 1'b1;
        state_next      = S_FINISH;
      end
      S_RM_WAIT: begin
        cmd.val_capture = 1'b1;
        if (sts.pos_at_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end else begin
          state_next = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ilir_pkg::RD_PTR;
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.wr_en        = 1'b1;
        cmd.wr_src_rdata = 1'b1;
        if (sts.op == ilir_pkg::OP_INSERT) begin
          cmd.wr_sel = ilir_pkg::WR_PTR_UP;
          if (sts.ptr_at_pos) begin
            state_next = S_INS_WR;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_next  = S_MOVE_RD;
          end
        end else begin
          cmd.wr_sel = ilir_pkg::WR_PTR_DN;
          if (sts.ptr_at_last) begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_FINISH;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_next  = S_MOVE_RD;
          end
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ilir_pkg::WR_POS;
        cmd.cnt_inc = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/ilir_dp.sv =====
// ----------------------------------------------------------------------------
// ilir_dp - list datapath
// Entry RAM, entry count, move pointer, range checks and result register.
// ----------------------------------------------------------------------------
module ilir_dp #(
  parameter int CAPACITY   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ilir_pkg::dp_cmd_t  cmd,
  output ilir_pkg::dp_sts_t  sts,
  input  logic        [2:0]  in_op,
  input  logic        [2:0]  in_position,
  input  logic signed [31:0] in_item,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic        [1:0]  out_status,
  output logic        [3:0]  out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = (CW > 3) ? CW : 3;

  logic [2:0]            op_reg;
  logic [W-1:0]          pos_w;
  logic [DATA_WIDTH-1:0] word;
  logic [CW-1:0]         cnt;
  logic [AW-1:0]         ptr;
  logic [DATA_WIDTH-1:0] val;
  ilir_pkg::status_t     st_reg;
  ilir_pkg::status_t     chk;
  ilir_pkg::op_t         op;

  logic [W-1:0]          cnt_w;
  logic [W-1:0]          cnt_m1;
  logic                  empty;
  logic                  full;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic signed [31:0]    val_ext;
  logic [DATA_WIDTH-1:0] word_in;

  // resize the item to the stored word and the stored word back to 32 bits
  generate
    if (DATA_WIDTH <= 32) begin : g_word_narrow
      assign word_in = in_item[DATA_WIDTH-1:0];
    end else begin : g_word_wide
      assign word_in = {{(DATA_WIDTH-32){in_item[31]}}, in_item};
    end
    if (DATA_WIDTH >= 32) begin : g_val_wide
      assign val_ext = val[31:0];
    end else begin : g_val_narrow
      assign val_ext = {{(32-DATA_WIDTH){val[DATA_WIDTH-1]}}, val};
    end
  endgenerate

  assign op     = ilir_pkg::op_t'(op_reg);
  assign cnt_w  = W'(cnt);
  assign cnt_m1 = cnt_w - W'(1);
  assign empty  = (cnt_w == '0);
  assign full   = (cnt_w == W'(CAPACITY));

  always_comb begin
    chk = ilir_pkg::ST_OK;
    case (op)
      ilir_pkg::OP_READ, ilir_pkg::OP_REMOVE: begin
        if (empty) begin
          chk = ilir_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          chk = ilir_pkg::ST_RANGE;
        end
      end
      ilir_pkg::OP_APPEND: begin
        if (full) begin
          chk = ilir_pkg::ST_FULL;
        end
      end
      ilir_pkg::OP_INSERT: begin
        if (empty) begin
          chk = ilir_pkg::ST_EMPTY;
        end else if (pos_w > cnt_w) begin
          chk = ilir_pkg::ST_RANGE;
        end else if (full) begin
          chk = ilir_pkg::ST_FULL;
        end
      end
      ilir_pkg::OP_POP: begin
        if (empty) begin
          chk = ilir_pkg::ST_EMPTY;
        end
      end
      default: chk = ilir_pkg::ST_OK;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      ilir_pkg::RD_POS:  rd_addr = pos_w[AW-1:0];
      ilir_pkg::RD_LAST: rd_addr = cnt_m1[AW-1:0];
      ilir_pkg::RD_PTR:  rd_addr = ptr;
      default:           rd_addr = ptr;
    endcase
    case (cmd.wr_sel)
      ilir_pkg::WR_COUNT:  wr_addr = cnt_w[AW-1:0];
      ilir_pkg::WR_POS:    wr_addr = pos_w[AW-1:0];
      ilir_pkg::WR_PTR_UP: wr_addr = ptr + AW'(1);
      ilir_pkg::WR_PTR_DN: wr_addr = ptr - AW'(1);
      default:             wr_addr = ptr;
    endcase
    wr_data = cmd.wr_src_rdata ? rd_data : word;
  end

  ilir_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    sts.op           = op;
    sts.chk          = chk;
    sts.pos_at_count = (pos_w == cnt_w);
    sts.pos_at_last  = (pos_w == cnt_m1);
    sts.ptr_at_pos   = (W'(ptr) == pos_w);
    sts.ptr_at_last  = (W'(ptr) == cnt_m1);
    sts.out_free     = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_reg <= in_op;
      pos_w  <= W'(in_position);
      word   <= word_in;
      val    <= '0;
    end else if (cmd.val_capture) begin
      val <= rd_data;
    end
    if (cmd.sts_latch) begin
      st_reg <= chk;
    end
    if (cmd.ptr_load) begin
      ptr <= cmd.ptr_sel_pos ? (pos_w[AW-1:0] + AW'(1)) : cnt_m1[AW-1:0];
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + AW'(1);
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - AW'(1);
    end
    if (cmd.out_load) begin
      out_value  <= val_ext;
      out_status <= st_reg;
      out_count  <= 4'(cnt);
    end
  end

endmodule

// ===== rtl/indexed_list_insert_remove_core.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core - fixed-capacity ordered list
// Each item on cmd is one list operation (read, append, insert, pop, remove);
// each gives exactly one result item on rsp with value, status and count.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries op, position and item; an item is taken when valid and ready
//   are both high. rsp returns value (read, popped or removed entry, zero on
//   append, insert, unused op codes and every rejection), status and the
//   entry count left after the operation.
//   Entries live in a simple dual-port RAM with registered read, so each
//   entry that moves during insert or remove is read in S_MOVE_RD and
//   written to its new place in S_MOVE_WR. One item is worked on at a
//   time; the result shows on rsp the cycle after the operation finishes.
//   A registered result slot lets the next item be taken while a result
//   still waits; if rsp stays stalled the block holds the next result
//   internally and stops taking items until the slot drains.
//   Reset empties the list (count zero); RAM contents are not cleared and
//   are never read before being written.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_core #(
  parameter int CAPACITY   = 8,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  ilir_cmd_if.sink   cmd,
  ilir_rsp_if.source rsp
);

  ilir_pkg::dp_cmd_t dp_cmd;
  ilir_pkg::dp_sts_t dp_sts;

  // sequencer: accept, check, move entries, hand over the result
  ilir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // entry storage, count and result register
  ilir_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .sts         (dp_sts),
    .in_op       (cmd.op),
    .in_position (cmd.position),
    .in_item     (cmd.item),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_value   (rsp.value),
    .out_status  (rsp.status),
    .out_count   (rsp.count)
  );

endmodule

// ===== rtl/ilir_chk.sv =====
// ----------------------------------------------------------------------------
// ilir_chk - port-level checks for the indexed list core
// Watches the cmd and rsp channels and flags inconsistent results.
// ----------------------------------------------------------------------------
module ilir_chk #(
  parameter int CAPACITY = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_value,
  input logic [1:0]  rsp_status,
  input logic [3:0]  rsp_count
);

  // a full rejection only happens with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == 2'(ilir_pkg::ST_FULL)) |-> rsp_count == 4'(CAPACITY))
    else $error("full status with count below capacity");

  // an empty rejection leaves the list empty
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == 2'(ilir_pkg::ST_EMPTY)) |-> rsp_count == 4'd0)
    else $error("empty status with nonzero count");

  // one operation at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item taken while the previous one is in progress");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
    else $error("stalled result changed");

endmodule

bind indexed_list_insert_remove_core ilir_chk #(
  .CAPACITY (CAPACITY)
) u_ilir_chk (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.value),
  .rsp_status (rsp.status),
  .rsp_count  (rsp.count)
);
